/* rtl/core/lzwh_pkg.sv */
// Shared types and constants of the hashed 12-bit LZW compressor.
// Used by the controller, the datapath and the top level.
`default_nettype none

package lzwh_pkg;

  // Code table geometry and block limits.
  localparam int TABLE_DEPTH = 4096;
  localparam int SLOT_W = 12;
  localparam logic [SLOT_W-1:0] PROBE_STEP = 12'd101;
  localparam logic [SLOT_W-1:0] INSERT_LIMIT = 12'd3840;
  localparam logic [17:0] KEY_SET_BIT = 18'h00800;
  localparam logic [17:0] ROOT_PRED_KEY = 18'h0FFFF;
  localparam logic [23:0] CAPACITY_RESET = 24'hFFFFFF;

  // One code table entry. A root entry has pred_root set in place of the all-ones predecessor.
  typedef struct packed {
    logic              used;
    logic [SLOT_W-1:0] link;
    logic              pred_root;
    logic [SLOT_W-1:0] pred;
    logic [7:0]        follow;
  } entry_t;

  // Output beat selection.
  typedef logic [2:0] emit_t;
  localparam emit_t EMIT_NONE = 3'd0;
  localparam emit_t EMIT_HI   = 3'd1;
  localparam emit_t EMIT_MID  = 3'd2;
  localparam emit_t EMIT_LO   = 3'd3;
  localparam emit_t EMIT_PAD  = 3'd4;
  localparam emit_t EMIT_ERR  = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  accept;
    logic  first;
    logic  set_root;
    logic  prime_q;
    logic  hash;
    logic  slot_home;
    logic  slot_link;
    logic  tail_mark;
    logic  slot_inc;
    logic  clr_wr;
    logic  wr_new;
    logic  wr_tail;
    logic  cur_slot;
    logic  cur_zero;
    logic  rcnt_inc;
    logic  ins_dec;
    logic  init;
    emit_t emit;
    logic  emit_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic match;
    logic used;
    logic link_zero;
    logic phase;
    logic cap0;
    logic cap1;
    logic ins_nz;
    logic clr_last;
    logic rcnt_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

/* rtl/core/lzw_12bit_hashed_compressor_top.sv */
// Top level of the hashed 12-bit LZW block compressor.
// Instantiates lzwh_ctrl and lzwh_datapath; depends on lzwh_pkg.
`default_nettype none

// The block compresses one block of bytes, ended by in_last, into packed
// big-endian 12-bit codes, one beat per output byte. Input beats are taken one
// at a time. A byte that extends the current string passes through the accept
// state, a hashed lookup over the code table memory (hash, home slot, read,
// compare) and a wrap-up state, plus a read and compare per collision chain
// link followed. A miss adds the capacity check, the output beats (one or two,
// held while the output stalls), the insert decision, the insert while inserts
// remain (hash, home slot, read, compare; when the home slot is taken a walk
// over the chain links to the tail, a read and compare per probed slot and the
// tail link write) and a root lookup. The last byte of a block adds the code
// output and, when half a byte is held, a capacity check and the pad beat.
// After reset and after every block end or overflow the table is prepared
// again: a clearing pass over all 4096 entries, one entry a cycle, then 256
// root inserts, each a priming step plus the insert; no input beat is taken
// during that time, while configuration writes are. The single table port
// sets the pace of all of these steps.
module lzw_12bit_hashed_compressor_top
  import lzwh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic             overflow_error,
  input  wire logic        cfg_en,
  input  wire logic [23:0] cfg_data
);

  cmd_t  cmd;
  stat_t st;

  // Controller.
  lzwh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (in_last),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath.
  lzwh_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .in_byte        (in_byte),
    .cfg_en         (cfg_en),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .overflow_error (overflow_error)
  );

endmodule

`default_nettype wire

/* rtl/core/lzwh_datapath.sv */
// Datapath of the LZW compressor: code table memory, hash unit, walk registers,
// code packer and output register. Depends on lzwh_pkg.
`default_nettype none

module lzwh_datapath
  import lzwh_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cmd_t       cmd,
  output stat_t           st,
  input  wire logic [7:0] in_byte,
  input  wire logic       cfg_en,
  input  wire logic [23:0] cfg_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            overflow_error
);

  entry_t mem [TABLE_DEPTH];
  entry_t rd;
  entry_t tail_e;
  entry_t wr_data;
  logic [SLOT_W-1:0] wr_addr;
  logic wr_en;

  logic              qroot;
  logic [SLOT_W-1:0] qpred;
  logic [7:0]        qb;
  logic [17:0]       key;
  logic [35:0]       prod;
  logic [17:0]       sq;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] tail;
  logic [SLOT_W-1:0] cur;
  logic [SLOT_W-1:0] clr_cnt;
  logic [7:0]        rcnt;
  logic [SLOT_W-1:0] inserts_left;
  logic [3:0]        held;
  logic              phase;
  logic [23:0]       bytes_written;
  logic [23:0]       capacity;
  logic [24:0]       bytes_plus1;

  // Mid-square hash key: predecessor plus sign-extended byte, with bit 11 forced.
  always_comb begin
    key = ((qroot ? ROOT_PRED_KEY : {6'b0, qpred}) + {{10{qb[7]}}, qb}) | KEY_SET_BIT;
    prod = {18'b0, key} * {18'b0, key};
  end

  // Table write port selection.
  always_comb begin
    wr_en = cmd.clr_wr | cmd.wr_new | cmd.wr_tail;
    wr_addr = slot;
    wr_data = '0;
    if (cmd.clr_wr) begin
      wr_addr = clr_cnt;
    end else if (cmd.wr_new) begin
      wr_data.used = 1'b1;
      wr_data.pred_root = qroot;
      wr_data.pred = qpred;
      wr_data.follow = qb;
    end else if (cmd.wr_tail) begin
      wr_addr = tail;
      wr_data = tail_e;
      wr_data.link = slot;
    end
  end

  // Code table memory with registered read at the walk slot.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd <= mem[slot];
  end

  // Query, hash and walk registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      qb <= in_byte;
      qroot <= cmd.first;
      qpred <= cur;
    end
    if (cmd.set_root) begin
      qroot <= 1'b1;
    end
    if (cmd.prime_q) begin
      qroot <= 1'b1;
      qpred <= '0;
      qb <= rcnt;
    end
    if (cmd.hash) begin
      sq <= prod[17:0];
    end
    if (cmd.slot_home) begin
      slot <= sq[17:6];
    end else if (cmd.slot_link) begin
      slot <= rd.link;
    end else if (cmd.tail_mark) begin
      tail <= slot;
      tail_e <= rd;
      slot <= slot + PROBE_STEP;
    end else if (cmd.slot_inc) begin
      slot <= slot + 12'd1;
    end
    if (cmd.cur_slot) begin
      cur <= slot;
    end else if (cmd.cur_zero || cmd.init) begin
      cur <= '0;
    end
    if (cmd.init) begin
      inserts_left <= INSERT_LIMIT;
    end else if (cmd.ins_dec) begin
      inserts_left <= inserts_left - 12'd1;
    end
  end

  // Clearing and priming counters and the capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      rcnt <= '0;
      capacity <= CAPACITY_RESET;
    end else begin
      if (cmd.clr_wr) begin
        clr_cnt <= clr_cnt + 12'd1;
      end
      if (cmd.rcnt_inc) begin
        rcnt <= rcnt + 8'd1;
      end
      if (cfg_en) begin
        capacity <= cfg_data;
      end
    end
  end

  // Code packer state.
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      held <= '0;
      phase <= 1'b1;
      bytes_written <= '0;
    end else begin
      case (cmd.emit)
        EMIT_HI: begin
          held <= cur[3:0];
          phase <= 1'b0;
          bytes_written <= bytes_written + 24'd1;
        end
        EMIT_LO: begin
          phase <= 1'b1;
          bytes_written <= bytes_written + 24'd2;
        end
        EMIT_PAD: begin
          bytes_written <= bytes_written + 24'd1;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: a beat loads when the register is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit != EMIT_NONE) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.emit)
      EMIT_HI: begin
        out_byte <= cur[11:4];
        out_last <= 1'b0;
        overflow_error <= 1'b0;
      end
      EMIT_MID: begin
        out_byte <= {held, cur[11:8]};
        out_last <= 1'b0;
        overflow_error <= 1'b0;
      end
      EMIT_LO: begin
        out_byte <= cur[7:0];
        out_last <= cmd.emit_last;
        overflow_error <= 1'b0;
      end
      EMIT_PAD: begin
        out_byte <= {held, 4'h0};
        out_last <= 1'b1;
        overflow_error <= 1'b0;
      end
      EMIT_ERR: begin
        out_byte <= 8'h00;
        out_last <= 1'b1;
        overflow_error <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Status toward the controller.
  always_comb begin
    bytes_plus1 = {1'b0, bytes_written} + 25'd1;
    st.match = (rd.pred_root == qroot) && (qroot || (rd.pred == qpred)) && (rd.follow == qb);
    st.used = rd.used;
    st.link_zero = (rd.link == '0);
    st.phase = phase;
    st.cap0 = (bytes_written >= capacity);
    st.cap1 = (bytes_plus1 >= {1'b0, capacity});
    st.ins_nz = (inserts_left != '0);
    st.clr_last = (clr_cnt == 12'hFFF);
    st.rcnt_last = (rcnt == 8'hFF);
    st.out_free = !out_valid || !out_stall;
  end

endmodule

`default_nettype wire

/* rtl/core/lzwh_ctrl.sv */
// Controller state machine of the LZW compressor: table preparation, lookups,
// inserts and code packing. Depends on lzwh_pkg.
`default_nettype none

module lzwh_ctrl
  import lzwh_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire logic  in_last,
  output logic       in_stall,
  input  wire stat_t st,
  output cmd_t       cmd
);

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_RQ   = 5'd1;
  localparam logic [4:0] I_H    = 5'd2;
  localparam logic [4:0] I_S    = 5'd3;
  localparam logic [4:0] I_R    = 5'd4;
  localparam logic [4:0] I_C    = 5'd5;
  localparam logic [4:0] I_TR   = 5'd6;
  localparam logic [4:0] I_TC   = 5'd7;
  localparam logic [4:0] I_PR   = 5'd8;
  localparam logic [4:0] I_PC   = 5'd9;
  localparam logic [4:0] I_WT   = 5'd10;
  localparam logic [4:0] S_INIT = 5'd11;
  localparam logic [4:0] S_IDLE = 5'd12;
  localparam logic [4:0] L_H    = 5'd13;
  localparam logic [4:0] L_S    = 5'd14;
  localparam logic [4:0] L_R    = 5'd15;
  localparam logic [4:0] L_C    = 5'd16;
  localparam logic [4:0] S_LAST = 5'd17;
  localparam logic [4:0] S_INS  = 5'd18;
  localparam logic [4:0] S_RLK  = 5'd19;
  localparam logic [4:0] P_CHK  = 5'd20;
  localparam logic [4:0] P_E0   = 5'd21;
  localparam logic [4:0] P_E1   = 5'd22;
  localparam logic [4:0] P_E2   = 5'd23;
  localparam logic [4:0] S_PAD  = 5'd24;
  localparam logic [4:0] P_EP   = 5'd25;
  localparam logic [4:0] S_FAIL = 5'd26;

  // Lookup return contexts.
  localparam logic [1:0] LK_FIRST = 2'd0;
  localparam logic [1:0] LK_CUR   = 2'd1;
  localparam logic [1:0] LK_ROOT  = 2'd2;

  // Insert and put return contexts.
  localparam logic CTX_MAIN = 1'b0;
  localparam logic CTX_SIDE = 1'b1;

  logic [4:0] state, state_next;
  logic       active, active_next;
  logic       err_seen, err_seen_next;
  logic       last_r, last_r_next;
  logic [1:0] lctx, lctx_next;
  logic       ictx, ictx_next;
  logic       pctx, pctx_next;
  logic [4:0] ins_ret;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      active <= 1'b0;
      err_seen <= 1'b0;
      last_r <= 1'b0;
      lctx <= LK_FIRST;
      ictx <= CTX_MAIN;
      pctx <= CTX_MAIN;
    end else begin
      state <= state_next;
      active <= active_next;
      err_seen <= err_seen_next;
      last_r <= last_r_next;
      lctx <= lctx_next;
      ictx <= ictx_next;
      pctx <= pctx_next;
    end
  end

  // Where an insert continues: the next root while priming (initialisation after the last root), else the root lookup.
  always_comb begin
    if (ictx == CTX_SIDE) begin
      ins_ret = st.rcnt_last ? S_INIT : S_RQ;
    end else begin
      ins_ret = S_RLK;
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    active_next = active;
    err_seen_next = err_seen;
    last_r_next = last_r;
    lctx_next = lctx;
    ictx_next = ictx;
    pctx_next = pctx;
    cmd = '0;
    cmd.emit = EMIT_NONE;
    unique case (state)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_last) begin
          state_next = S_RQ;
        end
      end
      S_RQ: begin
        cmd.prime_q = 1'b1;
        ictx_next = CTX_SIDE;
        state_next = I_H;
      end
      I_H: begin
        cmd.hash = 1'b1;
        state_next = I_S;
      end
      I_S: begin
        cmd.slot_home = 1'b1;
        state_next = I_R;
      end
      I_R: state_next = I_C;
      I_C: begin
        if (!st.used) begin
          cmd.wr_new = 1'b1;
          cmd.rcnt_inc = (ictx == CTX_SIDE);
          state_next = ins_ret;
        end else if (st.link_zero) begin
          cmd.tail_mark = 1'b1;
          state_next = I_PR;
        end else begin
          cmd.slot_link = 1'b1;
          state_next = I_TR;
        end
      end
      I_TR: state_next = I_TC;
      I_TC: begin
        if (st.link_zero) begin
          cmd.tail_mark = 1'b1;
          state_next = I_PR;
        end else begin
          cmd.slot_link = 1'b1;
          state_next = I_TR;
        end
      end
      I_PR: state_next = I_PC;
      I_PC: begin
        if (st.used) begin
          cmd.slot_inc = 1'b1;
          state_next = I_PR;
        end else begin
          cmd.wr_new = 1'b1;
          state_next = I_WT;
        end
      end
      I_WT: begin
        cmd.wr_tail = 1'b1;
        cmd.rcnt_inc = (ictx == CTX_SIDE);
        state_next = ins_ret;
      end
      S_INIT: begin
        cmd.init = 1'b1;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        // Beats after an overflow are dropped up to the end of the block.
        if (in_valid) begin
          if (err_seen) begin
            if (in_last) begin
              err_seen_next = 1'b0;
            end
          end else begin
            cmd.accept = 1'b1;
            cmd.first = !active;
            last_r_next = in_last;
            lctx_next = active ? LK_CUR : LK_FIRST;
            active_next = 1'b1;
            state_next = L_H;
          end
        end
      end
      L_H: begin
        cmd.hash = 1'b1;
        state_next = L_S;
      end
      L_S: begin
        cmd.slot_home = 1'b1;
        state_next = L_R;
      end
      L_R: state_next = L_C;
      L_C: begin
        if (st.match) begin
          cmd.cur_slot = 1'b1;
          state_next = S_LAST;
        end else if (st.link_zero) begin
          if (lctx == LK_CUR) begin
            pctx_next = CTX_MAIN;
            state_next = P_CHK;
          end else begin
            cmd.cur_zero = 1'b1;
            state_next = S_LAST;
          end
        end else begin
          cmd.slot_link = 1'b1;
          state_next = L_R;
        end
      end
      S_LAST: begin
        if (!last_r) begin
          state_next = S_IDLE;
        end else begin
          pctx_next = CTX_SIDE;
          state_next = P_CHK;
        end
      end
      S_INS: begin
        if (st.ins_nz) begin
          cmd.ins_dec = 1'b1;
          ictx_next = CTX_MAIN;
          state_next = I_H;
        end else begin
          state_next = S_RLK;
        end
      end
      S_RLK: begin
        cmd.set_root = 1'b1;
        lctx_next = LK_ROOT;
        state_next = L_H;
      end
      P_CHK: begin
        if (st.phase) begin
          state_next = st.cap0 ? S_FAIL : P_E0;
        end else begin
          state_next = st.cap1 ? S_FAIL : P_E1;
        end
      end
      P_E0: begin
        if (st.out_free) begin
          cmd.emit = EMIT_HI;
          state_next = (pctx == CTX_MAIN) ? S_INS : S_PAD;
        end
      end
      P_E1: begin
        if (st.out_free) begin
          cmd.emit = EMIT_MID;
          state_next = P_E2;
        end
      end
      P_E2: begin
        if (st.out_free) begin
          cmd.emit = EMIT_LO;
          cmd.emit_last = (pctx == CTX_SIDE);
          if (pctx == CTX_MAIN) begin
            state_next = S_INS;
          end else begin
            active_next = 1'b0;
            state_next = S_CLR;
          end
        end
      end
      S_PAD: begin
        state_next = st.cap0 ? S_FAIL : P_EP;
      end
      P_EP: begin
        if (st.out_free) begin
          cmd.emit = EMIT_PAD;
          active_next = 1'b0;
          state_next = S_CLR;
        end
      end
      S_FAIL: begin
        if (st.out_free) begin
          cmd.emit = EMIT_ERR;
          active_next = 1'b0;
          err_seen_next = !last_r;
          state_next = S_CLR;
        end
      end
      default: state_next = S_CLR;
    endcase
  end

endmodule

`default_nettype wire
